### rtl/core/assert_macros.svh
// Assertion macros shared by the address generator RTL.
// Expects signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

### rtl/core/sbm_pkg.sv
// Shared types, constants and helpers of the scaled blit address generator.
// No dependencies.
package sbm_pkg;

   // texture geometry
   localparam int TEX_WIDTH     = 1024;
   localparam int TEX_HEIGHT    = 512;
   localparam int TILE_DIM      = 8;
   localparam int TILE_TEXELS   = 64;
   localparam int TILES_PER_ROW = TEX_WIDTH / TILE_DIM;

   // field widths
   localparam int DX_W    = 10;
   localparam int DY_W    = 9;
   localparam int SRC_W   = 12;
   localparam int PITCH_W = 14;
   localparam int CW_W    = 11;
   localparam int CH_W    = 10;
   localparam int OFF_W   = 26;
   localparam int TILE_W  = 19;
   localparam int NUM_W   = 22;   // dest coord times source size
   localparam int QUO_W   = 12;   // quotient bits kept before the clamp

   // divider pipeline shape
   localparam int DIV_STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES          = QUO_W / DIV_STEPS_PER_STAGE;

   // csr port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_PITCH      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTENT_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTENT_HEIGHT = 3'd4;

   typedef struct packed {
      logic [SRC_W-1:0]   src_width;
      logic [SRC_W-1:0]   src_height;
      logic [PITCH_W-1:0] src_pitch;
      logic [CW_W-1:0]    content_width;
      logic [CH_W-1:0]    content_height;
   } sbm_cfg_type;

   // one restoring-division lane
   typedef struct packed {
      logic [NUM_W-1:0] rem;    // partial remainder
      logic [NUM_W-1:0] d_sh;   // divisor aligned to the current quotient bit
      logic [QUO_W-1:0] quo;
      logic             ovf;    // quotient does not fit QUO_W bits
   } sbm_lane_type;

   // fields that ride along with the division
   typedef struct packed {
      logic              in_range;
      logic [TILE_W-1:0] tile_offset;
   } sbm_side_type;

   // Morton spread of a 3-bit tile column: bits land at 0, 2, 4
   function automatic logic [5:0] morton_col(input logic [2:0] c);
      logic [5:0] r;
      case (c)
         3'd0: r = 6'd0;
         3'd1: r = 6'd1;
         3'd2: r = 6'd4;
         3'd3: r = 6'd5;
         3'd4: r = 6'd16;
         3'd5: r = 6'd17;
         3'd6: r = 6'd20;
         3'd7: r = 6'd21;
         default: r = 6'd0;
      endcase
      return r;
   endfunction

   // Morton spread of a 3-bit tile row: bits land at 1, 3, 5
   function automatic logic [5:0] morton_row(input logic [2:0] c);
      logic [5:0] r;
      case (c)
         3'd0: r = 6'd0;
         3'd1: r = 6'd2;
         3'd2: r = 6'd8;
         3'd3: r = 6'd10;
         3'd4: r = 6'd32;
         3'd5: r = 6'd34;
         3'd6: r = 6'd40;
         3'd7: r = 6'd42;
         default: r = 6'd0;
      endcase
      return r;
   endfunction

endpackage

### rtl/core/sbm_front.sv
// Front end: scale multiplies, range flag, tile offset, then overflow check.
// Depends on sbm_pkg.
module sbm_front import sbm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  sbm_cfg_type       cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DX_W-1:0]   dest_x,
   input  logic [DY_W-1:0]   dest_y,
   output logic              out_valid,
   input  logic              out_ready,
   output sbm_lane_type      out_lane_x,
   output sbm_lane_type      out_lane_y,
   output sbm_side_type      out_side
);

   // stage 1: products, range flag, tile index
   logic             f1_v_ff;
   logic [NUM_W-1:0] f1_nx_ff, f1_nx_in;
   logic [NUM_W-1:0] f1_ny_ff, f1_ny_in;
   sbm_side_type     f1_side_ff, f1_side_in;
   logic [31:0]      tile_wide;
   logic             f1_ready;

   // stage 2: overflow check, divisor alignment
   logic             f2_v_ff;
   sbm_lane_type     f2_lx_ff, f2_lx_in;
   sbm_lane_type     f2_ly_ff, f2_ly_in;
   sbm_side_type     f2_side_ff;
   logic             f2_ready;

   assign f2_ready = !f2_v_ff || out_ready;
   assign f1_ready = !f1_v_ff || f2_ready;
   assign in_ready = f1_ready;

   always_comb begin
      f1_nx_in = {{(NUM_W-DX_W){1'b0}}, dest_x} * {{(NUM_W-SRC_W){1'b0}}, cfg.src_width};
      f1_ny_in = {{(NUM_W-DY_W){1'b0}}, dest_y} * {{(NUM_W-SRC_W){1'b0}}, cfg.src_height};
      tile_wide = (32'(dest_y[DY_W-1:3]) * 32'(TILES_PER_ROW) + 32'(dest_x[DX_W-1:3]))
                  * 32'(TILE_TEXELS)
                  + 32'(morton_col(dest_x[2:0])) + 32'(morton_row(dest_y[2:0]));
      f1_side_in.tile_offset = tile_wide[TILE_W-1:0];
      f1_side_in.in_range = ({1'b0, dest_x} < cfg.content_width) &&
                            ({1'b0, dest_y} < cfg.content_height) &&
                            (int'(dest_x) < TEX_WIDTH) && (int'(dest_y) < TEX_HEIGHT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
      end else if (f1_ready) begin
         f1_v_ff <= in_valid;
      end
      if (f1_ready && in_valid) begin
         f1_nx_ff   <= f1_nx_in;
         f1_ny_ff   <= f1_ny_in;
         f1_side_ff <= f1_side_in;
      end
   end

   // quotient fits QUO_W bits only if numerator < divisor << QUO_W;
   // a zero divisor always flags overflow, which the clamp resolves
   always_comb begin
      f2_lx_in.rem  = f1_nx_ff;
      f2_lx_in.d_sh = {cfg.content_width, {(QUO_W-1){1'b0}}};
      f2_lx_in.quo  = '0;
      f2_lx_in.ovf  = {1'b0, f1_nx_ff} >= {cfg.content_width, {QUO_W{1'b0}}};
      f2_ly_in.rem  = f1_ny_ff;
      f2_ly_in.d_sh = {1'b0, cfg.content_height, {(QUO_W-1){1'b0}}};
      f2_ly_in.quo  = '0;
      f2_ly_in.ovf  = {1'b0, f1_ny_ff} >= {1'b0, cfg.content_height, {QUO_W{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_v_ff <= 1'b0;
      end else if (f2_ready) begin
         f2_v_ff <= f1_v_ff;
      end
      if (f2_ready && f1_v_ff) begin
         f2_lx_ff   <= f2_lx_in;
         f2_ly_ff   <= f2_ly_in;
         f2_side_ff <= f1_side_ff;
      end
   end

   assign out_valid  = f2_v_ff;
   assign out_lane_x = f2_lx_ff;
   assign out_lane_y = f2_ly_ff;
   assign out_side   = f2_side_ff;

endmodule

### rtl/core/sbm_div_stage.sv
// One divider stage: two restoring-division steps on both lanes.
// Depends on sbm_pkg.
module sbm_div_stage import sbm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  sbm_lane_type in_lane_x,
   input  sbm_lane_type in_lane_y,
   input  sbm_side_type in_side,
   output logic         out_valid,
   input  logic         out_ready,
   output sbm_lane_type out_lane_x,
   output sbm_lane_type out_lane_y,
   output sbm_side_type out_side
);

   logic         v_ff;
   sbm_lane_type lx_ff, lx_in;
   sbm_lane_type ly_ff, ly_in;
   sbm_side_type side_ff;

   function automatic sbm_lane_type div_step(input sbm_lane_type l);
      sbm_lane_type r;
      r = l;
      if (l.rem >= l.d_sh) begin
         r.rem = l.rem - l.d_sh;
         r.quo = {l.quo[QUO_W-2:0], 1'b1};
      end else begin
         r.quo = {l.quo[QUO_W-2:0], 1'b0};
      end
      r.d_sh = l.d_sh >> 1;
      return r;
   endfunction

   always_comb begin
      lx_in = in_lane_x;
      ly_in = in_lane_y;
      for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
         lx_in = div_step(lx_in);
         ly_in = div_step(ly_in);
      end
   end

   assign in_ready = !v_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         lx_ff   <= lx_in;
         ly_ff   <= ly_in;
         side_ff <= in_side;
      end
   end

   assign out_valid  = v_ff;
   assign out_lane_x = lx_ff;
   assign out_lane_y = ly_ff;
   assign out_side   = side_ff;

endmodule

### rtl/core/sbm_back.sv
// Back end: clamp to source size, row times pitch, final byte offset.
// Depends on sbm_pkg.
module sbm_back import sbm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  sbm_cfg_type       cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  sbm_lane_type      in_lane_x,
   input  sbm_lane_type      in_lane_y,
   input  sbm_side_type      in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_in_range,
   output logic [SRC_W-1:0]  out_src_x,
   output logic [SRC_W-1:0]  out_src_y,
   output logic [OFF_W-1:0]  out_src_byte_offset,
   output logic [TILE_W-1:0] out_tile_offset
);

   // stage 1: clamp
   logic             b1_v_ff;
   logic [SRC_W-1:0] b1_sx_ff, b1_sx_in;
   logic [SRC_W-1:0] b1_sy_ff, b1_sy_in;
   sbm_side_type     b1_side_ff;
   logic [SRC_W-1:0] top_x, top_y;
   logic             b1_ready;

   // stage 2: row offset product
   logic             b2_v_ff;
   logic [OFF_W-1:0] b2_prod_ff, b2_prod_in;
   logic [SRC_W-1:0] b2_sx_ff, b2_sy_ff;
   sbm_side_type     b2_side_ff;
   logic             b2_ready;

   // stage 3: output register
   logic             b3_v_ff;
   logic [OFF_W-1:0] b3_off_ff, b3_off_in;
   logic [SRC_W-1:0] b3_sx_ff, b3_sy_ff;
   sbm_side_type     b3_side_ff;
   logic             b3_ready;

   assign b3_ready = !b3_v_ff || out_ready;
   assign b2_ready = !b2_v_ff || b3_ready;
   assign b1_ready = !b1_v_ff || b2_ready;
   assign in_ready = b1_ready;

   always_comb begin
      top_x = (cfg.src_width == '0) ? '0 : cfg.src_width - SRC_W'(1);
      top_y = (cfg.src_height == '0) ? '0 : cfg.src_height - SRC_W'(1);
      b1_sx_in = (in_lane_x.ovf || in_lane_x.quo > top_x) ? top_x : in_lane_x.quo;
      b1_sy_in = (in_lane_y.ovf || in_lane_y.quo > top_y) ? top_y : in_lane_y.quo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff <= 1'b0;
      end else if (b1_ready) begin
         b1_v_ff <= in_valid;
      end
      if (b1_ready && in_valid) begin
         b1_sx_ff   <= b1_sx_in;
         b1_sy_ff   <= b1_sy_in;
         b1_side_ff <= in_side;
      end
   end

   assign b2_prod_in = {{(OFF_W-SRC_W){1'b0}}, b1_sy_ff} *
                       {{(OFF_W-PITCH_W){1'b0}}, cfg.src_pitch};

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_v_ff <= 1'b0;
      end else if (b2_ready) begin
         b2_v_ff <= b1_v_ff;
      end
      if (b2_ready && b1_v_ff) begin
         b2_prod_ff <= b2_prod_in;
         b2_sx_ff   <= b1_sx_ff;
         b2_sy_ff   <= b1_sy_ff;
         b2_side_ff <= b1_side_ff;
      end
   end

   // sum wraps to OFF_W bits
   assign b3_off_in = b2_prod_ff + {{(OFF_W-SRC_W-1){1'b0}}, b2_sx_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         b3_v_ff <= 1'b0;
      end else if (b3_ready) begin
         b3_v_ff <= b2_v_ff;
      end
      if (b3_ready && b2_v_ff) begin
         b3_off_ff  <= b3_off_in;
         b3_sx_ff   <= b2_sx_ff;
         b3_sy_ff   <= b2_sy_ff;
         b3_side_ff <= b2_side_ff;
      end
   end

   assign out_valid           = b3_v_ff;
   assign out_in_range        = b3_side_ff.in_range;
   assign out_src_x           = b3_sx_ff;
   assign out_src_y           = b3_sy_ff;
   assign out_src_byte_offset = b3_off_ff;
   assign out_tile_offset     = b3_side_ff.tile_offset;

endmodule

### rtl/core/scaled_blit_morton_address_gen.sv
// Top level of the scaled blit / Morton tile address generator.
// Depends on sbm_pkg, sbm_front, sbm_div_stage, sbm_back, assert_macros.svh.
//
//   port group | dir | transaction
//   req_*      | in  | one destination texel (dest_x, dest_y), valid/ready
//   rsp_*      | out | range flag, source x/y, source byte offset, tile offset
//   csr_*      | in  | register write, index 0..4, no read-back
//
// The pipe holds 2 front stages (multiply, overflow check), 6 divider
// stages at 2 quotient bits each, and 3 back stages (clamp, pitch multiply, add).
// Throughput is one transaction per cycle unless rsp stalls; the 2-bit divider stage sets the depth.
// Reset (synchronous) clears the valid bits and loads the register defaults.
// Every stage has its own ready, so bubbles collapse and a stalled rsp side
// holds its data; new requests keep filling until the pipe is full.
`include "assert_macros.svh"

module scaled_blit_morton_address_gen import sbm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [DX_W-1:0]       req_dest_x,
   input  logic [DY_W-1:0]       req_dest_y,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_in_range,
   output logic [SRC_W-1:0]      rsp_src_x,
   output logic [SRC_W-1:0]      rsp_src_y,
   output logic [OFF_W-1:0]      rsp_src_byte_offset,
   output logic [TILE_W-1:0]     rsp_tile_offset,
   // register write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   logic [SRC_W-1:0]   src_width_ff;
   logic [SRC_W-1:0]   src_height_ff;
   logic [PITCH_W-1:0] src_pitch_ff;
   logic [CW_W-1:0]    content_width_ff;
   logic [CH_W-1:0]    content_height_ff;
   sbm_cfg_type        cfg;

   // divider chain; index 0 is the front end output
   logic         div_v   [DIV_STAGES+1];
   logic         div_rdy [DIV_STAGES+1];
   sbm_lane_type div_lx  [DIV_STAGES+1];
   sbm_lane_type div_ly  [DIV_STAGES+1];
   sbm_side_type div_sd  [DIV_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff      <= SRC_W'(640);
         src_height_ff     <= SRC_W'(480);
         src_pitch_ff      <= PITCH_W'(1280);
         content_width_ff  <= CW_W'(640);
         content_height_ff <= CH_W'(480);
      end else if (csr_we) begin
         case (csr_index)
            CSR_SRC_WIDTH:      src_width_ff      <= csr_wdata[SRC_W-1:0];
            CSR_SRC_HEIGHT:     src_height_ff     <= csr_wdata[SRC_W-1:0];
            CSR_SRC_PITCH:      src_pitch_ff      <= csr_wdata[PITCH_W-1:0];
            CSR_CONTENT_WIDTH:  content_width_ff  <= csr_wdata[CW_W-1:0];
            CSR_CONTENT_HEIGHT: content_height_ff <= csr_wdata[CH_W-1:0];
            default: ;  // unknown index: write dropped
         endcase
      end
   end

   // the user must change registers only while the pipe is empty, unenforced; stages read them live
   assign cfg.src_width      = src_width_ff;
   assign cfg.src_height     = src_height_ff;
   assign cfg.src_pitch      = src_pitch_ff;
   assign cfg.content_width  = content_width_ff;
   assign cfg.content_height = content_height_ff;

   sbm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .dest_x     (req_dest_x),
      .dest_y     (req_dest_y),
      .out_valid  (div_v[0]),
      .out_ready  (div_rdy[0]),
      .out_lane_x (div_lx[0]),
      .out_lane_y (div_ly[0]),
      .out_side   (div_sd[0])
   );

   // floor(d * size / content), MSB quotient bits first
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      sbm_div_stage u_div (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (div_v[g]),
         .in_ready   (div_rdy[g]),
         .in_lane_x  (div_lx[g]),
         .in_lane_y  (div_ly[g]),
         .in_side    (div_sd[g]),
         .out_valid  (div_v[g+1]),
         .out_ready  (div_rdy[g+1]),
         .out_lane_x (div_lx[g+1]),
         .out_lane_y (div_ly[g+1]),
         .out_side   (div_sd[g+1])
      );
   end

   sbm_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .in_valid            (div_v[DIV_STAGES]),
      .in_ready            (div_rdy[DIV_STAGES]),
      .in_lane_x           (div_lx[DIV_STAGES]),
      .in_lane_y           (div_ly[DIV_STAGES]),
      .in_side             (div_sd[DIV_STAGES]),
      .out_valid           (rsp_valid),
      .out_ready           (rsp_ready),
      .out_in_range        (rsp_in_range),
      .out_src_x           (rsp_src_x),
      .out_src_y           (rsp_src_y),
      .out_src_byte_offset (rsp_src_byte_offset),
      .out_tile_offset     (rsp_tile_offset)
   );

   // clamp keeps source coordinates inside the surface
   `ASSERT_NEVER(a_src_x_bound, rsp_valid && src_width_ff != '0 && rsp_src_x >= src_width_ff, "src_x beyond source width")
   `ASSERT_NEVER(a_src_y_bound, rsp_valid && src_height_ff != '0 && rsp_src_y >= src_height_ff, "src_y beyond source height")
   // offset parity follows row times pitch, since the column term is even
   `ASSERT_NEVER(a_offset_parity, rsp_valid && (rsp_src_byte_offset[0] != (rsp_src_y[0] & src_pitch_ff[0])), "byte offset parity mismatch")
   // an empty output stage must leave the whole pipe open
   `ASSERT_CLK(a_ready_when_drained, !rsp_valid |-> req_ready, "request stalled with empty output")

endmodule
